[sv/timestamp_clock_recovery_loop_core_assert.svh]
// Assertion macros shared by the clock recovery loop checkers.
`ifndef TIMESTAMP_CLOCK_RECOVERY_LOOP_CORE_ASSERT_SVH
`define TIMESTAMP_CLOCK_RECOVERY_LOOP_CORE_ASSERT_SVH

// Check cons in the same cycle as ante, sampled on clk, off during reset.
`define TCRL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcrl assertion failed");

// Check cons in the cycle after ante, sampled on clk, off during reset.
`define TCRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcrl assertion failed");

`endif

[sv/tcrl_pkg.sv]
// Shared constants, types and helpers of the clock recovery loop.
package tcrl_pkg;

    localparam int CLOCK_WIDTH = 32;
    localparam int FRAC_W      = 16;
    localparam int FINE_WIDTH  = CLOCK_WIDTH + FRAC_W;
    localparam int SRC_W       = 32;
    localparam int TICKS_W     = 24;
    localparam int Q_W         = 48;
    localparam int SAT_W       = FINE_WIDTH + 2;

    localparam int ALPHA_W     = 24;
    localparam int GAIN_W      = 48;
    localparam int THR_W       = 16;

    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 64;

    localparam int DIG_W       = 24;
    localparam int PROD_W      = 2 * DIG_W;
    localparam int ACC_W       = 4 * DIG_W;

    localparam int SHIFT_TICKS = 30;
    localparam int SHIFT_ALPHA = 24;
    localparam int SHIFT_GAIN  = 18;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(1678);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(5212500);
    localparam logic [THR_W-1:0]   THR_RST   = THR_W'(100);

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_THR   = 2'd2;

    // Rounding offset selects for the multiply-accumulate unit.
    localparam logic [1:0] RND_TICKS = 2'd0;
    localparam logic [1:0] RND_ALPHA = 2'd1;
    localparam logic [1:0] RND_GAIN  = 2'd2;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic                 init;
        logic [1:0]           rnd;
        logic                 issue;
        logic [1:0]           shift;
    } tcrl_mac_ctl_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]   alpha;
        logic [GAIN_W-1:0]    gain;
        logic [THR_W-1:0]     thr;
    } tcrl_cfg_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SAT_W'(Q_MAX))
            r = Q_MAX;
        else if (v < SAT_W'(Q_MIN))
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

[sv/tcrl_mac.sv]
// Shared 24x24 multiply-accumulate unit with registered partial product.
module tcrl_mac
    import tcrl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcrl_mac_ctl_t        ctl,
    input  logic [DIG_W-1:0]     op_a,
    input  logic [DIG_W-1:0]     op_b,
    output logic [ACC_W-1:0]     acc
);

    logic [PROD_W-1:0] pp_reg,    pp_next;
    logic              pp_vld_reg, pp_vld_next;
    logic [1:0]        shift_reg, shift_next;
    logic [ACC_W-1:0]  acc_reg,   acc_next;
    logic [ACC_W-1:0]  rnd_const;

    assign pp_next     = PROD_W'(op_a) * PROD_W'(op_b);
    assign pp_vld_next = ctl.issue;
    assign shift_next  = ctl.shift;

    always_comb
    begin
        case (ctl.rnd)
            RND_TICKS: rnd_const = ACC_W'(1) << (SHIFT_TICKS - 1);
            RND_ALPHA: rnd_const = ACC_W'(1) << (SHIFT_ALPHA - 1);
            RND_GAIN:  rnd_const = ACC_W'(1) << (SHIFT_GAIN - 1);
            default:   rnd_const = '0;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.init)
        begin
            acc_next = rnd_const;
        end
        else if (pp_vld_reg)
        begin
            case (shift_reg)
                2'd0:    acc_next = acc_reg + ACC_W'(pp_reg);
                2'd1:    acc_next = acc_reg + (ACC_W'(pp_reg) << DIG_W);
                2'd2:    acc_next = acc_reg + (ACC_W'(pp_reg) << (2 * DIG_W));
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_vld_reg <= 1'b0;
            shift_reg  <= '0;
        end
        else
        begin
            pp_vld_reg <= pp_vld_next;
            shift_reg  <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[sv/tcrl_regs.sv]
// APB configuration registers of the clock recovery loop.
module tcrl_regs
    import tcrl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output tcrl_cfg_t            cfg
);

    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [GAIN_W-1:0]  gain_reg,  gain_next;
    logic [THR_W-1:0]   thr_reg,   thr_next;
    logic [1:0]         idx;
    logic               wr_en;

    assign idx   = paddr[PADDR_W-1:3];
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        alpha_next = alpha_reg;
        gain_next  = gain_reg;
        thr_next   = thr_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ALPHA: alpha_next = pwdata[ALPHA_W-1:0];
                REG_GAIN:  gain_next  = pwdata[GAIN_W-1:0];
                REG_THR:   thr_next   = pwdata[THR_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (psel)
        begin
            case (idx)
                REG_ALPHA: prdata = PDATA_W'(alpha_reg);
                REG_GAIN:  prdata = PDATA_W'(gain_reg);
                REG_THR:   prdata = PDATA_W'(thr_reg);
                default:   prdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
            gain_reg  <= GAIN_RST;
            thr_reg   <= THR_RST;
        end
        else
        begin
            alpha_reg <= alpha_next;
            gain_reg  <= gain_next;
            thr_reg   <= thr_next;
        end
    end

    assign cfg.alpha = alpha_reg;
    assign cfg.gain  = gain_reg;
    assign cfg.thr   = thr_reg;

endmodule

[sv/timestamp_clock_recovery_loop_core.sv]
// Top level of the timestamp clock recovery loop: sequencer and datapath.
//
// Usage:
//   Timestamp channel (ts_valid/ts_ready, source_clock, local_ticks) takes one
//   received timestamp per request. Result channel (res_valid/res_ready) gives
//   one request per timestamp: recovered_clock, filtered_drift, drift_rate_out,
//   resynced. The APB port (8-byte register stride) holds filter_alpha,
//   scaled_loop_gain and resync_threshold; write it only while the loop is idle.
// Sequencing:
//   The first timestamp after reset loads the counters and goes straight to
//   the drift step. Every later timestamp runs the full sequence, and a new
//   timestamp is taken only once the last one's result is in the result
//   register. The sequence is set by the single 24x24 multiplier: eight
//   partial products (two for ticks times rate, two for the lowpass, four
//   for the loop gain), each product group followed by a drain step, plus
//   a state each for the counter, resync and saturation steps.
// Reset:
//   Counters, filter state and drift rate clear; registers take their defaults.
// Stalls:
//   The result register holds while res_ready is low; the loop may take the
//   next timestamp meanwhile, but parks before its own result until it drains.
module timestamp_clock_recovery_loop_core
    import tcrl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // timestamp channel
    input  logic                     ts_valid,
    output logic                     ts_ready,
    input  logic [SRC_W-1:0]         source_clock,
    input  logic [TICKS_W-1:0]       local_ticks,
    // result channel
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [SRC_W-1:0]         recovered_clock,
    output logic signed [Q_W-1:0]    filtered_drift,
    output logic signed [Q_W-1:0]    drift_rate_out,
    output logic                     resynced,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int DELTA_W = 45;
    localparam int RA_W    = 43;
    localparam int RB_W    = 49;
    localparam logic [2:0] STEPS_SHORT = 3'd2;
    localparam logic [2:0] STEPS_LONG  = 3'd4;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_MUL_A  = 12'b0000_0000_0010,
        S_DELTA  = 12'b0000_0000_0100,
        S_CNT    = 12'b0000_0000_1000,
        S_GAP    = 12'b0000_0001_0000,
        S_DRIFT  = 12'b0000_0010_0000,
        S_MUL_B  = 12'b0000_0100_0000,
        S_FILT   = 12'b0000_1000_0000,
        S_PREP_C = 12'b0001_0000_0000,
        S_MUL_C  = 12'b0010_0000_0000,
        S_RATE   = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } tcrl_state_t;

    tcrl_cfg_t      cfg;
    tcrl_mac_ctl_t  mac_ctl;
    logic [ACC_W-1:0] mac_acc;
    logic [DIG_W-1:0] mac_a, mac_b;

    // control state
    tcrl_state_t    state_reg, state_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic           started_reg, started_next;
    logic           res_valid_reg, res_valid_next;

    // loop state
    logic [CLOCK_WIDTH-1:0]  int_reg, int_next;
    logic [FINE_WIDTH-1:0]   fine_reg, fine_next;
    logic signed [Q_W-1:0]   filt_reg, filt_next;
    logic signed [Q_W-1:0]   rate_reg, rate_next;
    logic                    resync_reg, resync_next;

    // working registers
    logic [SRC_W-1:0]        src_reg, src_next;
    logic [Q_W-1:0]          mag_reg, mag_next;
    logic [Q_W-1:0]          opb_reg, opb_next;
    logic                    neg_reg, neg_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;

    // result register
    logic [SRC_W-1:0]        out_clk_reg, out_clk_next;
    logic signed [Q_W-1:0]   out_filt_reg, out_filt_next;
    logic signed [Q_W-1:0]   out_rate_reg, out_rate_next;
    logic                    out_rs_reg, out_rs_next;

    // datapath terms
    logic [RA_W-1:0]           ra;
    logic signed [DELTA_W-1:0] ra_s, delta_s, delta_rnd;
    logic [CLOCK_WIDTH-1:0]    inc_ext;
    logic signed [FINE_WIDTH-1:0] gap_s, drift_w;
    logic [FINE_WIDTH-1:0]     gap_mag;
    logic signed [Q_W-1:0]     drift_q;
    logic signed [Q_W:0]       diff_s;
    logic [Q_W-1:0]            diff_mag, rate_mag, filt_mag;
    logic [RB_W-1:0]           rb, rc;
    logic signed [RB_W:0]      rb_s, rc_s;
    logic signed [Q_W-1:0]     filt_upd, rate_upd;
    logic                      res_free;

    tcrl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tcrl_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc)
    );

    assign pready = 1'b1;

    // Digit select: cnt bit 0 walks the magnitude, bit 1 walks the coefficient.
    assign mac_a = cnt_reg[0] ? mag_reg[2*DIG_W-1:DIG_W] : mag_reg[DIG_W-1:0];
    assign mac_b = cnt_reg[1] ? opb_reg[2*DIG_W-1:DIG_W] : opb_reg[DIG_W-1:0];

    // Ticks times rate, rounded, signed, plus the whole-tick advance.
    assign ra      = mac_acc[SHIFT_TICKS+RA_W-1:SHIFT_TICKS];
    assign ra_s    = neg_reg ? -$signed({2'b00, ra}) : $signed({2'b00, ra});
    assign delta_s = $signed({5'b0, opb_reg[TICKS_W-1:0], {FRAC_W{1'b0}}}) + ra_s;

    // Round the Q.16 advance half up to whole ticks for the integer counter.
    assign delta_rnd = delta_reg + $signed(DELTA_W'(32768));
    assign inc_ext   = CLOCK_WIDTH'($signed(delta_rnd[DELTA_W-1:FRAC_W]));

    // Gap between fine and integer counters.
    assign gap_s   = $signed(fine_reg - {int_reg, {FRAC_W{1'b0}}});
    assign gap_mag = gap_s[FINE_WIDTH-1] ? FINE_WIDTH'(-gap_s) : FINE_WIDTH'(gap_s);

    // Drift of the source against the fine counter, and its step into the filter.
    assign drift_w  = $signed({CLOCK_WIDTH'(src_reg), {FRAC_W{1'b0}}} - fine_reg);
    assign drift_q  = sat_q(SAT_W'(drift_w));
    assign diff_s   = $signed({drift_q[Q_W-1], drift_q}) - $signed({filt_reg[Q_W-1], filt_reg});
    assign diff_mag = diff_s[Q_W] ? Q_W'(-diff_s) : Q_W'(diff_s);

    assign rate_mag = rate_reg[Q_W-1] ? Q_W'(-rate_reg) : Q_W'(rate_reg);
    assign filt_mag = filt_reg[Q_W-1] ? Q_W'(-filt_reg) : Q_W'(filt_reg);

    // Lowpass update.
    assign rb       = mac_acc[SHIFT_ALPHA+RB_W-1:SHIFT_ALPHA];
    assign rb_s     = $signed({1'b0, rb});
    assign filt_upd = sat_q(SAT_W'(filt_reg) + SAT_W'(neg_reg ? -rb_s : rb_s));

    // Rate update; clamp the gain product at 2^48, which saturates the rate anyway
    // and keeps the sum inside the saturation width.
    assign rc       = (|mac_acc[ACC_W-1:SHIFT_GAIN+RB_W-1]) ? {1'b1, {(RB_W-1){1'b0}}}
                                                             : mac_acc[SHIFT_GAIN+RB_W-1:SHIFT_GAIN];
    assign rc_s     = $signed({1'b0, rc});
    assign rate_upd = sat_q(SAT_W'(rate_reg) + SAT_W'(neg_reg ? -rc_s : rc_s));

    assign res_free = !res_valid_reg || res_ready;
    assign ts_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        started_next   = started_reg;
        res_valid_next = res_valid_reg && !res_ready;
        int_next       = int_reg;
        fine_next      = fine_reg;
        filt_next      = filt_reg;
        rate_next      = rate_reg;
        resync_next    = resync_reg;
        src_next       = src_reg;
        mag_next       = mag_reg;
        opb_next       = opb_reg;
        neg_next       = neg_reg;
        delta_next     = delta_reg;
        out_clk_next   = out_clk_reg;
        out_filt_next  = out_filt_reg;
        out_rate_next  = out_rate_reg;
        out_rs_next    = out_rs_reg;
        mac_ctl.init   = 1'b0;
        mac_ctl.rnd    = RND_TICKS;
        mac_ctl.issue  = 1'b0;
        mac_ctl.shift  = 2'(cnt_reg[0]) + 2'(cnt_reg[1]);

        case (state_reg)
            S_IDLE:
            begin
                if (ts_valid)
                begin
                    src_next    = source_clock;
                    opb_next    = Q_W'(local_ticks);
                    resync_next = 1'b0;
                    if (!started_reg)
                    begin
                        // First timestamp: load both counters, clear the loop.
                        started_next = 1'b1;
                        int_next     = CLOCK_WIDTH'(source_clock);
                        fine_next    = {CLOCK_WIDTH'(source_clock), {FRAC_W{1'b0}}};
                        filt_next    = '0;
                        rate_next    = '0;
                        state_next   = S_DRIFT;
                    end
                    else
                    begin
                        mag_next     = rate_mag;
                        neg_next     = rate_reg[Q_W-1];
                        mac_ctl.init = 1'b1;
                        mac_ctl.rnd  = RND_TICKS;
                        cnt_next     = '0;
                        state_next   = S_MUL_A;
                    end
                end
            end
            S_MUL_A:
            begin
                if (cnt_reg == STEPS_SHORT)
                begin
                    state_next = S_DELTA;
                end
                else
                begin
                    mac_ctl.issue = 1'b1;
                    cnt_next      = cnt_reg + 3'd1;
                end
            end
            S_DELTA:
            begin
                delta_next = delta_s;
                state_next = S_CNT;
            end
            S_CNT:
            begin
                int_next   = int_reg + inc_ext;
                fine_next  = fine_reg + FINE_WIDTH'(delta_reg);
                state_next = S_GAP;
            end
            S_GAP:
            begin
                if (gap_mag > FINE_WIDTH'({cfg.thr, {FRAC_W{1'b0}}}))
                begin
                    fine_next   = {int_reg, {FRAC_W{1'b0}}};
                    resync_next = 1'b1;
                end
                state_next = S_DRIFT;
            end
            S_DRIFT:
            begin
                mag_next     = diff_mag;
                neg_next     = diff_s[Q_W];
                opb_next     = Q_W'(cfg.alpha);
                mac_ctl.init = 1'b1;
                mac_ctl.rnd  = RND_ALPHA;
                cnt_next     = '0;
                state_next   = S_MUL_B;
            end
            S_MUL_B:
            begin
                if (cnt_reg == STEPS_SHORT)
                begin
                    state_next = S_FILT;
                end
                else
                begin
                    mac_ctl.issue = 1'b1;
                    cnt_next      = cnt_reg + 3'd1;
                end
            end
            S_FILT:
            begin
                filt_next  = filt_upd;
                state_next = S_PREP_C;
            end
            S_PREP_C:
            begin
                mag_next     = filt_mag;
                neg_next     = filt_reg[Q_W-1];
                opb_next     = cfg.gain;
                mac_ctl.init = 1'b1;
                mac_ctl.rnd  = RND_GAIN;
                cnt_next     = '0;
                state_next   = S_MUL_C;
            end
            S_MUL_C:
            begin
                if (cnt_reg == STEPS_LONG)
                begin
                    state_next = S_RATE;
                end
                else
                begin
                    mac_ctl.issue = 1'b1;
                    cnt_next      = cnt_reg + 3'd1;
                end
            end
            S_RATE:
            begin
                rate_next  = rate_upd;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold here until the result register is free.
                if (res_free)
                begin
                    out_clk_next   = int_reg[SRC_W-1:0];
                    out_filt_next  = filt_reg;
                    out_rate_next  = rate_reg;
                    out_rs_next    = resync_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            int_reg       <= '0;
            fine_reg      <= '0;
            filt_reg      <= '0;
            rate_reg      <= '0;
            resync_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            res_valid_reg <= res_valid_next;
            int_reg       <= int_next;
            fine_reg      <= fine_next;
            filt_reg      <= filt_next;
            rate_reg      <= rate_next;
            resync_reg    <= resync_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        mag_reg      <= mag_next;
        opb_reg      <= opb_next;
        neg_reg      <= neg_next;
        delta_reg    <= delta_next;
        out_clk_reg  <= out_clk_next;
        out_filt_reg <= out_filt_next;
        out_rate_reg <= out_rate_next;
        out_rs_reg   <= out_rs_next;
    end

    assign res_valid       = res_valid_reg;
    assign recovered_clock = out_clk_reg;
    assign filtered_drift  = out_filt_reg;
    assign drift_rate_out  = out_rate_reg;
    assign resynced        = out_rs_reg;

endmodule

[sv/tcrl_chk.sv]
// Port-level checker of the clock recovery loop, bound to the top level.
`include "timestamp_clock_recovery_loop_core_assert.svh"

module tcrl_chk
    import tcrl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ts_valid,
    input  logic                     ts_ready,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  logic [SRC_W-1:0]         recovered_clock,
    input  logic signed [Q_W-1:0]    filtered_drift,
    input  logic signed [Q_W-1:0]    drift_rate_out,
    input  logic                     resynced
);

    // A stalled result holds.
    `TCRL_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(recovered_clock) && $stable(filtered_drift) && $stable(drift_rate_out) && $stable(resynced))

    // Busy once a timestamp is taken.
    `TCRL_ASSERT_NEXT(a_busy_after_accept, ts_valid && ts_ready, !ts_ready)

    // No result in the cycle right after a timestamp is taken.
    `TCRL_ASSERT_NEXT(a_no_instant_result, ts_valid && ts_ready, !$rose(res_valid))

    // A new result only comes out of a busy loop.
    `TCRL_ASSERT_SAME(a_result_from_busy, $rose(res_valid), !$past(ts_ready))

endmodule

bind timestamp_clock_recovery_loop_core tcrl_chk u_tcrl_chk (.*);

[sim/timestamp_clock_recovery_loop_core_tb.sv]
// Self-checking testbench for the timestamp clock recovery loop core.
`timescale 1ns / 1ps

module timestamp_clock_recovery_loop_core_tb;
    import tcrl_pkg::*;

    // Run sizing: one directed burst, then random phases under changing settings.
    localparam int          RANDOM_PHASES  = 11;
    localparam int          PHASE_ITEMS    = 90;
    localparam int          DRAIN_CYCLES   = 30;    // a little over the loop period
    localparam int          STALL_LIMIT    = 4000;  // cycles with no request moving
    localparam int          MAX_PRINTS     = 40;
    localparam int unsigned SEND_IDLE_PCT  = 40;
    localparam int unsigned TAKE_STALL_PCT = 25;

    // Address slot past the three registers; writes there must change nothing.
    localparam logic [1:0]  REG_SPARE      = 2'd3;

    localparam longint      Q_HI           = Q_MAX;
    localparam longint      Q_LO           = Q_MIN;

    typedef struct {
        logic [SRC_W-1:0]   source_clock;
        logic [TICKS_W-1:0] local_ticks;
    } timestamp_t;

    typedef struct {
        logic [SRC_W-1:0]        recovered_clock;
        logic signed [Q_W-1:0]   filtered_drift;
        logic signed [Q_W-1:0]   drift_rate_out;
        logic                    resynced;
    } loop_result_t;

    // ------------------------------------------------------------------
    // Block inputs: every one holds a known value from time zero.
    // ------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     ts_valid = 1'b0;
    logic                     ts_ready;
    logic [SRC_W-1:0]         source_clock = '0;
    logic [TICKS_W-1:0]       local_ticks = '0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    logic [SRC_W-1:0]         recovered_clock;
    logic signed [Q_W-1:0]    filtered_drift;
    logic signed [Q_W-1:0]    drift_rate_out;
    logic                     resynced;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    // ------------------------------------------------------------------
    // Loop shadow: the settings and state the predictor keeps for itself.
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0]       cfg_alpha = ALPHA_RST;
    logic [GAIN_W-1:0]        cfg_gain = GAIN_RST;
    logic [THR_W-1:0]         cfg_thr = THR_RST;

    bit                       loop_locked = 1'b0;
    logic [CLOCK_WIDTH-1:0]   int_count = '0;
    logic [FINE_WIDTH-1:0]    fine_count = '0;
    longint                   drift_lp = 0;
    longint                   freq_corr = 0;

    timestamp_t               pending[$];            // timestamps not yet offered
    loop_result_t             expected_results[$];   // predictions awaiting their result

    bit                       steady_flow = 1'b0;    // phase with no idling on either side
    logic [SRC_W-1:0]         stream_src = '0;
    int unsigned              ts_lull = 0;
    int unsigned              ready_lull = 0;
    int                       idle_cycles = 0;

    int                       err_count = 0;
    int                       sent_count = 0;
    int                       results_seen = 0;
    int                       resync_seen = 0;
    int                       clamp_seen = 0;
    int                       settings_used = 1;     // reset values count as the first

    timestamp_clock_recovery_loop_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .ts_valid        (ts_valid),
        .ts_ready        (ts_ready),
        .source_clock    (source_clock),
        .local_ticks     (local_ticks),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .recovered_clock (recovered_clock),
        .filtered_drift  (filtered_drift),
        .drift_rate_out  (drift_rate_out),
        .resynced        (resynced),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers for the predictor.
    // ------------------------------------------------------------------

    // Unsigned a*b / 2^sh, rounded half up, clamped at 2^62.
    function automatic logic [63:0] round_mul_shift(logic [63:0] a, logic [63:0] b,
                                                    int unsigned sh);
        logic [129:0] full;
        logic [129:0] q;
        full = {66'd0, a} * {66'd0, b} + (130'd1 << (sh - 1));
        q = full >> sh;
        if (q > (130'd1 << 62))
            return 64'd1 << 62;
        return q[63:0];
    endfunction

    // Signed version: round the magnitude, so halves go away from zero.
    function automatic longint signed_round_mul(longint v, logic [63:0] m, int unsigned sh);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r = round_mul_shift(mag, m, sh);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Read a wrapped fine-counter difference as two's complement.
    function automatic longint sext_fine(logic [FINE_WIDTH-1:0] x);
        logic signed [FINE_WIDTH-1:0] s;
        s = x;
        return s;
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    // Advance the shadow loop by one timestamp and return the result it must give.
    function automatic loop_result_t advance_loop(logic [SRC_W-1:0] src,
                                                  logic [TICKS_W-1:0] ticks);
        loop_result_t           r;
        longint                 delta;
        longint                 gap;
        longint                 drift;
        longint                 diff;
        logic [63:0]            gap_mag;
        logic [CLOCK_WIDTH-1:0] int_step;
        r.resynced = 1'b0;
        if (!loop_locked)
        begin
            // First timestamp: load both counters and clear the loop.
            loop_locked = 1'b1;
            int_count = src;
            fine_count = {src, 16'h0000};
            drift_lp = 0;
            freq_corr = 0;
        end
        else
        begin
            // Advance by ticks * (1 + rate); the integer counter takes the
            // Q.16 increment rounded half up to whole ticks.
            delta = (longint'(ticks) <<< 16) + signed_round_mul(freq_corr, 64'(ticks), SHIFT_TICKS);
            int_step = CLOCK_WIDTH'((delta + 32768) >>> 16);
            int_count = int_count + int_step;
            fine_count = fine_count + FINE_WIDTH'(delta);
            gap = sext_fine(fine_count - {int_count, 16'h0000});
            gap_mag = (gap < 0) ? 64'(-gap) : 64'(gap);
            if (gap_mag > (64'(cfg_thr) << 16))
            begin
                fine_count = {int_count, 16'h0000};
                r.resynced = 1'b1;
            end
        end
        drift = clamp_q(sext_fine({src, 16'h0000} - fine_count));
        diff = drift - drift_lp;
        drift_lp = clamp_q(drift_lp + signed_round_mul(diff, 64'(cfg_alpha), SHIFT_ALPHA));
        freq_corr = clamp_q(freq_corr + signed_round_mul(drift_lp, 64'(cfg_gain), SHIFT_GAIN));
        r.recovered_clock = int_count;
        r.filtered_drift = drift_lp[Q_W-1:0];
        r.drift_rate_out = freq_corr[Q_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and idle pacing.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %h, want %h", what, got, want));
    endtask

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int unsigned pick_gap(int unsigned busy_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll >= busy_pct)
            return 0;
        if (roll < busy_pct / 8)
            return $urandom_range(25, 120);
        if (roll < busy_pct / 3)
            return $urandom_range(7, 24);
        return $urandom_range(1, 6);
    endfunction

    // ------------------------------------------------------------------
    // Timestamp driver: offer the pending queue one request at a time,
    // predict each request at the edge that accepts it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_timestamps
        bit          fired;
        int unsigned lull;
        timestamp_t  nxt;
        if (!rst_n)
        begin
            ts_valid <= 1'b0;
            ts_lull <= 0;
        end
        else
        begin
            fired = ts_valid && ts_ready;
            if (fired)
            begin
                expected_results.push_back(advance_loop(source_clock, local_ticks));
                sent_count++;
            end
            // Hold an offered request until it is taken.
            if (!ts_valid || ts_ready)
            begin
                lull = fired ? pick_gap(SEND_IDLE_PCT) : 0;
                if (lull != 0)
                begin
                    ts_valid <= 1'b0;
                    ts_lull <= lull - 1;
                end
                else if (ts_lull != 0)
                begin
                    ts_valid <= 1'b0;
                    ts_lull <= ts_lull - 1;
                end
                else if (pending.size() != 0)
                begin
                    nxt = pending.pop_front();
                    ts_valid <= 1'b1;
                    source_clock <= nxt.source_clock;
                    local_ticks <= nxt.local_ticks;
                end
                else
                    ts_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken request with the oldest prediction,
    // and stall the result side at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        loop_result_t want;
        int unsigned  lull;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            ready_lull <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no timestamp outstanding",
                                              results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    check_field($sformatf("result %0d recovered_clock", results_seen),
                                64'(recovered_clock), 64'(want.recovered_clock));
                    check_field($sformatf("result %0d filtered_drift", results_seen),
                                64'(filtered_drift), 64'(want.filtered_drift));
                    check_field($sformatf("result %0d drift_rate_out", results_seen),
                                64'(drift_rate_out), 64'(want.drift_rate_out));
                    check_field($sformatf("result %0d resynced", results_seen),
                                64'(resynced), 64'(want.resynced));
                end
                if (resynced)
                    resync_seen++;
                if (drift_rate_out == Q_MAX || drift_rate_out == Q_MIN)
                    clamp_seen++;
            end
            if (ready_lull != 0)
            begin
                res_ready <= 1'b0;
                ready_lull <= ready_lull - 1;
            end
            else
            begin
                lull = pick_gap(TAKE_STALL_PCT);
                res_ready <= (lull == 0);
                ready_lull <= (lull == 0) ? 0 : lull - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no request moves for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ts_valid && ts_ready) || (res_valid && res_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Configuration access: setup cycle, then access cycle; read data is
    // sampled mid access cycle.
    // ------------------------------------------------------------------
    task automatic apb_access(input logic is_write, input logic [1:0] idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= PADDR_W'({idx, 3'b000});
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all three registers with junk above their widths, poke the spare
    // slot, then read every register back.
    task automatic program_loop(logic [ALPHA_W-1:0] alpha, logic [GAIN_W-1:0] gain,
                                logic [THR_W-1:0] thr);
        logic [PDATA_W-1:0] junk;
        logic [PDATA_W-1:0] rd;
        junk = {$urandom(), $urandom()};
        apb_access(1'b1, REG_ALPHA, {junk[PDATA_W-1:ALPHA_W], alpha}, rd);
        junk = {$urandom(), $urandom()};
        apb_access(1'b1, REG_GAIN, {junk[PDATA_W-1:GAIN_W], gain}, rd);
        junk = {$urandom(), $urandom()};
        apb_access(1'b1, REG_THR, {junk[PDATA_W-1:THR_W], thr}, rd);
        apb_access(1'b1, REG_SPARE, {$urandom(), $urandom()}, rd);
        cfg_alpha = alpha;
        cfg_gain = gain;
        cfg_thr = thr;
        apb_access(1'b0, REG_ALPHA, '0, rd);
        check_field("filter_alpha readback", rd, 64'(alpha));
        apb_access(1'b0, REG_GAIN, '0, rd);
        check_field("scaled_loop_gain readback", rd, 64'(gain));
        apb_access(1'b0, REG_THR, '0, rd);
        check_field("resync_threshold readback", rd, 64'(thr));
        settings_used++;
    endtask

    // Wait until every offered timestamp has its result, then let the loop settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending.size() != 0 || ts_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial
    begin
        longint span;
        longint tick_step;
        int     ppm;
        int     jit;
        int     roll;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed burst at reset settings. The first request only loads the
        // counters, so its tick count must be ignored.
        pending.push_back('{32'hFFFF_FF00, 24'hFF_FFFF});
        pending.push_back('{32'h0000_0010, 24'h00_0110});   // counters wrap through zero
        pending.push_back('{32'h0000_0010, 24'h00_0000});   // no local ticks
        pending.push_back('{32'hFFFF_FFFF, 24'h00_0000});   // source at top: large drift
        pending.push_back('{32'h0000_0000, 24'hFF_FFFF});   // widest tick count
        pending.push_back('{32'h8000_0000, 24'h00_0001});   // drift near the Q32.16 edge
        pending.push_back('{32'h7FFF_FFFF, 24'h80_0000});
        pending.push_back('{32'h5555_5555, 24'hAA_AAAA});
        pending.push_back('{32'hAAAA_AAAA, 24'h55_5555});
        stream_src = 32'hAAAA_AAAA;
        repeat (12)
        begin
            // Source runs slightly fast against the local clock.
            stream_src += 32'd27_003;
            pending.push_back('{stream_src, 24'd27_000});
        end
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 6)
                0: program_loop('1, '1, '0);
                1: program_loop('0, '0, '1);
                2: program_loop(ALPHA_RST, GAIN_RST, THR_RST);
                3: program_loop(ALPHA_W'($urandom()), GAIN_W'($urandom_range(0, 32'h3FFF_FFFF)),
                                THR_W'($urandom_range(0, 300)));
                4: program_loop(ALPHA_W'($urandom()), GAIN_W'({$urandom(), $urandom()}),
                                THR_W'($urandom()));
                default: program_loop(ALPHA_W'(1) << (ALPHA_W - 1), GAIN_W'(1) << 20, THR_W'(1));
            endcase
            steady_flow = (p % 4 == 3);

            // Mostly coherent timestamp streams, some restarts and raw noise.
            while (pending.size() < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    stream_src = $urandom();
                if (roll < 8)
                begin
                    span = ($urandom_range(0, 4) == 0) ? longint'($urandom_range(1, 300))
                                                       : longint'($urandom_range(20_000, 3_000_000));
                    ppm = int'($urandom_range(0, 600)) - 300;
                    jit = int'($urandom_range(0, 40));
                    repeat ($urandom_range(8, 40))
                    begin
                        tick_step = span + longint'($urandom_range(0, 2 * jit)) - jit;
                        if (tick_step < 0)
                            tick_step = 0;
                        stream_src += SRC_W'(tick_step + tick_step * ppm / 1_000_000
                                             + longint'($urandom_range(0, 2 * jit)) - jit);
                        pending.push_back('{stream_src, TICKS_W'(tick_step)});
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        pending.push_back('{SRC_W'($urandom()), TICKS_W'($urandom())});
                end
            end
            wait_drained();
        end

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Sent %0d timestamps under %0d loop settings; %0d results checked.",
                 sent_count, settings_used, results_seen);
        $display("Saw %0d fine counter resyncs and %0d drift rate clamps; %0d mismatches.",
                 resync_seen, clamp_seen, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
